// ===== design/bfa_pkg.sv =====
// Package for the best-fit block allocator: sizes, status codes, register indices,
// controller states and the command/status structs between controller and datapath.
`default_nettype none
package bfa_pkg;
  localparam int MaxBlocks = 64;
  localparam int IdxW = $clog2(MaxBlocks);
  localparam int CntW = $clog2(MaxBlocks + 1);
  localparam int AlignBytes = 16;
  localparam int AlignW = $clog2(AlignBytes);
  localparam logic [33:0] HdrBytes = 34'd16;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_OOM = 2'd1, ST_FULL = 2'd2, ST_BADFREE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_HEAP_BASE = 2'd0, REG_HEAP_LIMIT = 2'd1, REG_NONE = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CHK, S_DEC, S_SPLIT, S_APPEND, S_FSCAN, S_FCHK, S_OUT
  } state_t;

  typedef struct packed {
    logic start_alloc;
    logic start_free;
    logic rd_walk;
    logic eval_walk;
    logic do_split;
    logic do_append;
    logic rd_scan;
    logic eval_scan;
    logic load_out;
    status_t out_status;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic found;
    logic split_wanted;
    logic spare_ok;
    logic oom;
    logic scan_done;
    logic scan_hit;
  } sts_t;
endpackage
`default_nettype wire

// ===== design/bfa_if.sv =====
// Valid/ready channel interface for the allocator's request and result items.
// Depends on nothing.
`default_nettype none
interface bfa_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] request_size;
  logic [31:0] release_address;
  modport source (output valid, req_type, request_size, release_address, input ready);
  modport sink (input valid, req_type, request_size, release_address, output ready);
endinterface

interface bfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] granted_address;
  logic [1:0]  status;
  modport source (output valid, granted_address, status, input ready);
  modport sink (input valid, granted_address, status, output ready);
endinterface
`default_nettype wire

// ===== design/bfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module bfa_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/bfa_ctrl.sv =====
// Controller state machine of the allocator. Depends on bfa_pkg.
`default_nettype none
module bfa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire logic          in_is_free,
  input  wire logic          out_busy,
  input  wire bfa_pkg::sts_t sts,
  output      logic          in_ready,
  output      bfa_pkg::cmd_t cmd
);
  bfa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.out_status = bfa_pkg::ST_OK;
    in_ready = 1'b0;
    unique case (state_r)
      bfa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (in_is_free) begin
            cmd.start_free = 1'b1;
            state_nxt = bfa_pkg::S_FSCAN;
          end else begin
            cmd.start_alloc = 1'b1;
            state_nxt = bfa_pkg::S_RD;
          end
        end
      end
      bfa_pkg::S_RD: begin
        // Stop once the tail has been evaluated (or the list is empty).
        if (sts.walk_done) begin
          state_nxt = bfa_pkg::S_DEC;
        end else begin
          cmd.rd_walk = 1'b1;
          state_nxt = bfa_pkg::S_CHK;
        end
      end
      bfa_pkg::S_CHK: begin
        cmd.eval_walk = 1'b1;
        state_nxt = bfa_pkg::S_RD;
      end
      bfa_pkg::S_DEC: begin
        state_nxt = sts.found ? bfa_pkg::S_SPLIT : bfa_pkg::S_APPEND;
      end
      bfa_pkg::S_SPLIT: begin
        if (!out_busy) begin
          cmd.do_split = 1'b1;
          cmd.load_out = 1'b1;
          state_nxt = bfa_pkg::S_IDLE;
        end
      end
      bfa_pkg::S_APPEND: begin
        if (!out_busy) begin
          cmd.load_out = 1'b1;
          if (sts.oom) begin
            cmd.out_status = bfa_pkg::ST_OOM;
          end else if (!sts.spare_ok) begin
            cmd.out_status = bfa_pkg::ST_FULL;
          end else begin
            cmd.do_append = 1'b1;
          end
          state_nxt = bfa_pkg::S_IDLE;
        end
      end
      bfa_pkg::S_FSCAN: begin
        // Stop on a match or after the last entry has been evaluated.
        if (sts.scan_hit || sts.scan_done) begin
          state_nxt = bfa_pkg::S_OUT;
        end else begin
          cmd.rd_scan = 1'b1;
          state_nxt = bfa_pkg::S_FCHK;
        end
      end
      bfa_pkg::S_FCHK: begin
        cmd.eval_scan = 1'b1;
        state_nxt = bfa_pkg::S_FSCAN;
      end
      bfa_pkg::S_OUT: begin
        if (!out_busy) begin
          cmd.load_out = 1'b1;
          cmd.out_status = sts.scan_hit ? bfa_pkg::ST_OK : bfa_pkg::ST_BADFREE;
          state_nxt = bfa_pkg::S_IDLE;
        end
      end
      default: state_nxt = bfa_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/bfa_dp.sv =====
// Datapath of the allocator: block table RAMs, flag bits, list pointers, heap
// top, best-fit walk, free scan and result register. Depends on bfa_pkg, bfa_ram.
`default_nettype none
module bfa_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bfa_pkg::cmd_t cmd,
  input  wire logic [31:0]   in_size,
  input  wire logic [31:0]   in_addr,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_idx,
  input  wire logic [31:0]   cfg_data,
  input  wire logic          out_take,
  output      bfa_pkg::sts_t sts,
  output      logic          out_valid,
  output      logic [31:0]   out_addr,
  output      logic [1:0]    out_status
);
  localparam int IW = bfa_pkg::IdxW;

  logic [31:0] limit_r, top_r;
  logic [33:0] need_r;
  logic [31:0] addr_r;
  logic [IW-1:0] head_r, tail_r, walk_r, best_r, spare_r;
  logic nonempty_r, walk_done_r, found_r, spare_ok_r;
  logic [32:0] best_slack_r;
  logic [bfa_pkg::CntW-1:0] step_r;
  logic [bfa_pkg::MaxBlocks-1:0] used_r, valid_r;
  logic hit_r, sdone_r;
  logic [31:0] best_start_r, best_size_r;
  logic [IW-1:0] best_link_r;
  logic out_valid_r;
  logic [31:0] out_addr_r;
  logic [1:0] out_status_r;

  // RAM ports
  logic st_we, sz_we, ln_we, st_we2;
  logic [IW-1:0] st_wa, sz_wa, ln_wa, rd_a;
  logic [31:0] st_wd, sz_wd, st_rd, sz_rd;
  logic [IW-1:0] ln_wd, ln_rd;

  logic st_we_f, sz_we_f, ln_we_f;
  logic [IW-1:0] st_wa_f, sz_wa_f, ln_wa_f, ln_wd_f;
  logic [31:0] st_wd_f, sz_wd_f;

  bfa_ram #(.Width(32), .Depth(bfa_pkg::MaxBlocks)) u_start (
    .clk(clk), .we(st_we_f), .waddr(st_wa_f), .wdata(st_wd_f), .raddr(rd_a),
    .rdata(st_rd));
  bfa_ram #(.Width(32), .Depth(bfa_pkg::MaxBlocks)) u_size (
    .clk(clk), .we(sz_we_f), .waddr(sz_wa_f), .wdata(sz_wd_f), .raddr(rd_a),
    .rdata(sz_rd));
  bfa_ram #(.Width(IW), .Depth(bfa_pkg::MaxBlocks)) u_link (
    .clk(clk), .we(ln_we_f), .waddr(ln_wa_f), .wdata(ln_wd_f), .raddr(rd_a),
    .rdata(ln_rd));

  // First free entry, found by priority over the valid bits.
  logic [IW-1:0] spare_nxt;
  logic spare_ok_nxt;
  always_comb begin
    spare_nxt = '0;
    spare_ok_nxt = 1'b0;
    for (int i = bfa_pkg::MaxBlocks - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        spare_nxt = IW'(i);
        spare_ok_nxt = 1'b1;
      end
    end
  end

  logic [33:0] need_nxt;
  assign need_nxt = ({2'b00, in_size} + bfa_pkg::HdrBytes + 34'(bfa_pkg::AlignBytes - 1))
                    & ~34'(bfa_pkg::AlignBytes - 1);

  // Walk evaluation on registered RAM data.
  logic fits;
  logic [32:0] slack;
  assign fits = !used_r[walk_r] && ({2'b00, sz_rd} >= need_r);
  assign slack = 33'({2'b00, sz_rd} - need_r);

  logic [33:0] new_top;
  assign new_top = {2'b00, top_r} + need_r;
  logic [33:0] rem;
  assign rem = {2'b00, best_size_r} - need_r;
  logic split_go;
  assign split_go = (rem > bfa_pkg::HdrBytes) && spare_ok_r;

  assign sts.walk_done = walk_done_r;
  assign sts.found = found_r;
  assign sts.split_wanted = rem > bfa_pkg::HdrBytes;
  assign sts.spare_ok = spare_ok_r;
  assign sts.oom = new_top > {2'b00, limit_r};
  assign sts.scan_done = sdone_r;
  assign sts.scan_hit = hit_r;

  assign rd_a = cmd.rd_scan ? step_r[IW-1:0] : walk_r;

  // Table writes: primary block (start/size/link), second write on link.
  always_comb begin
    st_we = 1'b0; st_wa = best_r; st_wd = top_r;
    sz_we = 1'b0; sz_wa = best_r; sz_wd = need_r[31:0];
    ln_we = 1'b0; ln_wa = best_r; ln_wd = spare_r;
    st_we2 = 1'b0;
    if (cmd.do_split) begin
      sz_we = split_go || (rem <= bfa_pkg::HdrBytes);
      ln_we = split_go;
    end else if (cmd.do_append) begin
      st_we = 1'b1; st_wa = spare_r;
      sz_we = 1'b1; sz_wa = spare_r;
      ln_we = nonempty_r; ln_wa = tail_r; ln_wd = spare_r;
    end
  end

  // New split-off entry goes in a second pass the next cycle.
  logic pend_r;
  logic [IW-1:0] pend_idx_r, pend_link_r;
  logic [31:0] pend_start_r, pend_size_r;
  logic [IW-1:0] wa2;
  assign wa2 = pend_idx_r;

  // Split entry fields write through a small second-pass path.
  logic w2;
  assign w2 = pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '1; top_r <= '0;
      head_r <= '0; tail_r <= '0; nonempty_r <= 1'b0;
      used_r <= '0; valid_r <= '0; out_valid_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.do_split && split_go;
      if (cfg_we) begin
        if (cfg_idx == bfa_pkg::REG_HEAP_BASE) begin
          if (!nonempty_r) top_r <= cfg_data;
        end else if (cfg_idx == bfa_pkg::REG_HEAP_LIMIT) begin
          limit_r <= cfg_data;
        end
      end
      if (cmd.start_alloc || cmd.start_free) begin
        need_r <= need_nxt; addr_r <= in_addr;
        walk_r <= head_r; step_r <= '0;
        best_slack_r <= '1; found_r <= 1'b0;
        walk_done_r <= !nonempty_r; hit_r <= 1'b0; sdone_r <= 1'b0;
        spare_r <= spare_nxt; spare_ok_r <= spare_ok_nxt;
      end
      if (cmd.eval_walk) begin
        if (fits && (slack < best_slack_r)) begin
          best_slack_r <= slack; best_r <= walk_r; found_r <= 1'b1;
          best_start_r <= st_rd; best_size_r <= sz_rd; best_link_r <= ln_rd;
        end
        walk_done_r <= (walk_r == tail_r);
        walk_r <= ln_rd;
      end
      if (cmd.eval_scan) begin
        if (valid_r[step_r[IW-1:0]] && ({2'b00, st_rd} + bfa_pkg::HdrBytes == {2'b00, addr_r})) begin
          hit_r <= 1'b1;
          used_r[step_r[IW-1:0]] <= 1'b0;
        end
        sdone_r <= (step_r == bfa_pkg::CntW'(bfa_pkg::MaxBlocks - 1));
        step_r <= step_r + 1'b1;
      end
      if (cmd.do_split) begin
        used_r[best_r] <= 1'b1;
        if (split_go) begin
          pend_idx_r <= spare_r; pend_link_r <= best_link_r;
          pend_start_r <= best_start_r + need_r[31:0];
          pend_size_r <= rem[31:0];
          valid_r[spare_r] <= 1'b1; used_r[spare_r] <= 1'b0;
          if (best_r == tail_r) tail_r <= spare_r;
        end
      end
      if (cmd.do_append) begin
        used_r[spare_r] <= 1'b1; valid_r[spare_r] <= 1'b1;
        tail_r <= spare_r;
        if (!nonempty_r) head_r <= spare_r;
        nonempty_r <= 1'b1;
        top_r <= new_top[31:0];
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
        out_status_r <= cmd.out_status;
        if (cmd.do_split) out_addr_r <= best_start_r + 32'd16;
        else if (cmd.do_append) out_addr_r <= top_r + 32'd16;
        else out_addr_r <= '0;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Second write pass for the split entry, muxed onto the RAM write ports ahead of the primary writes.
  logic [31:0] st2, sz2;
  logic [IW-1:0] ln2;
  assign st2 = pend_start_r;
  assign sz2 = pend_size_r;
  assign ln2 = pend_link_r;

  assign st_we_f = w2 | st_we | st_we2;
  assign st_wa_f = w2 ? wa2 : st_wa;
  assign st_wd_f = w2 ? st2 : st_wd;
  assign sz_we_f = w2 | sz_we;
  assign sz_wa_f = w2 ? wa2 : sz_wa;
  assign sz_wd_f = w2 ? sz2 : sz_wd;
  assign ln_we_f = w2 | ln_we;
  assign ln_wa_f = w2 ? wa2 : ln_wa;
  assign ln_wd_f = w2 ? ln2 : ln_wd;

  assign out_valid = out_valid_r;
  assign out_addr = out_addr_r;
  assign out_status = out_status_r;
endmodule
`default_nettype wire

// ===== design/best_fit_block_allocator.sv =====
// Top level of the best-fit block allocator. Depends on bfa_pkg, bfa_if,
// bfa_ctrl, bfa_dp, bfa_ram.
//
// Takes one allocate or free item at a time and returns one result item per
// request. An allocate walks the address-ordered block list through the
// registered table RAMs, reading each entry in S_RD and evaluating it in S_CHK.
// A free scans the entry table, reading each entry in S_FSCAN and evaluating it
// in S_FCHK, until an entry matches or the last entry has been evaluated. The
// result register frees the datapath while the result waits on out_ready; a new
// request is taken once the previous one has been handed to it.
`default_nettype none
module best_fit_block_allocator (
  input  wire logic       clk,
  input  wire logic       rst_n,
  bfa_req_if.sink         in_ch,
  bfa_rsp_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  bfa_pkg::cmd_t cmd;
  bfa_pkg::sts_t sts;
  logic in_ready, in_fire, out_take;

  assign in_ch.ready = in_ready;
  assign in_fire = in_ch.valid && in_ready;
  assign out_take = out_ch.valid && out_ch.ready;

  // Hold the result while it waits; a new result may load once it is taken.
  bfa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_is_free(in_ch.req_type),
    .out_busy(out_ch.valid && !out_ch.ready), .sts(sts), .in_ready(in_ready),
    .cmd(cmd));

  bfa_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_size(in_ch.request_size),
    .in_addr(in_ch.release_address), .cfg_we(cfg_we), .cfg_idx(cfg_index),
    .cfg_data(cfg_data), .out_take(out_take), .sts(sts), .out_valid(out_ch.valid),
    .out_addr(out_ch.granted_address), .out_status(out_ch.status));

`ifndef SYNTHESIS
  // A failed request never carries an address.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != bfa_pkg::ST_OK |-> out_ch.granted_address == 32'd0)
    else $error("failed request returned an address");
  // A request is never taken while the controller is busy with another.
  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("request accepted while busy");
`endif
endmodule
`default_nettype wire
